@@ rtl/core/cdta_pkg.sv @@
// Shared types, codes and constants for the calendar date/time adder.
// Used by cdta_ctrl, cdta_dp and calendar_datetime_adder; no dependencies.
package cdta_pkg;

  localparam int AMOUNT_WIDTH_DEF = 20;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 14;

  // operation codes
  localparam logic [2:0] OP_ADD_SEC  = 3'd0;
  localparam logic [2:0] OP_ADD_MIN  = 3'd1;
  localparam logic [2:0] OP_ADD_HOUR = 3'd2;
  localparam logic [2:0] OP_ADD_DAY  = 3'd3;
  localparam logic [2:0] OP_LOAD     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MONTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd5;

  // reset date and time
  localparam logic [13:0] RST_YEAR   = 14'd2021;
  localparam logic [3:0]  RST_MONTH  = 4'd1;
  localparam logic [4:0]  RST_DAY    = 5'd1;
  localparam logic [4:0]  RST_HOUR   = 5'd0;
  localparam logic [5:0]  RST_MINUTE = 6'd0;
  localparam logic [5:0]  RST_SECOND = 6'd0;

  localparam logic [13:0] MAX_YEAR      = 14'd9999;
  localparam logic [13:0] YEARS_400     = 14'd400;
  localparam logic [13:0] SKIP_YEAR_MAX = MAX_YEAR - YEARS_400;
  localparam int          DAYS_400Y     = 146097;
  localparam logic [3:0]  MAX_MONTH     = 4'd12;
  localparam logic [4:0]  MAX_HOUR      = 5'd23;
  localparam logic [5:0]  MAX_MIN_SEC   = 6'd59;
  localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
  localparam logic [6:0]  HOURS_PER_DAY = 7'd24;

  // floor(y / 100) = (y * LEAP_RECIP) >> LEAP_SHIFT for y below 16384
  localparam logic [12:0] LEAP_RECIP = 13'd5243;
  localparam int          LEAP_SHIFT = 19;

  typedef struct packed {
    logic [2:0]  operation;
    logic [19:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic        year_overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR
  } unit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LEAP_Q,
    ST_LEAP_F,
    ST_CLAMP,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_DAY_INIT,
    ST_DAY_STEP,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic  take;
    logic  load;
    logic  leap_q;
    logic  leap_f;
    logic  clamp;
    logic  div_init;
    logic  div_step;
    logic  div_done;
    logic  day_init;
    logic  day_step;
    logic  put;
    unit_t unit;
    logic  use_amt;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic ovf;
    logic new_year;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

@@ rtl/core/cdta_ctrl.sv @@
// Sequencer for the date/time adder: steps the datapath through load,
// divide, day-walk and result phases. Depends on cdta_pkg.
module cdta_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_op,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output cdta_pkg::cmd_t    cmd,
  input  cdta_pkg::status_t st
);
  import cdta_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  unit_t      unit_r, unit_nxt;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unit_nxt  = unit_r;
    first_nxt = first_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          first_nxt = 1'b1;
          case (in_op)
            OP_ADD_SEC: begin
              unit_nxt  = UNIT_SEC;
              state_nxt = ST_DIV_INIT;
            end
            OP_ADD_MIN: begin
              unit_nxt  = UNIT_MIN;
              state_nxt = ST_DIV_INIT;
            end
            OP_ADD_HOUR: begin
              unit_nxt  = UNIT_HOUR;
              state_nxt = ST_DIV_INIT;
            end
            OP_ADD_DAY: state_nxt = ST_DAY_INIT;
            OP_LOAD:    state_nxt = ST_LOAD;
            default:    state_nxt = ST_PUT;
          endcase
        end
      end
      ST_LOAD:     state_nxt = ST_LEAP_Q;
      ST_LEAP_Q:   state_nxt = ST_LEAP_F;
      ST_LEAP_F:   state_nxt = (op_r == OP_LOAD) ? ST_CLAMP : ST_DAY_STEP;
      ST_CLAMP:    state_nxt = ST_PUT;
      ST_DIV_INIT: state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:  state_nxt = ST_DIV_DONE;
      ST_DIV_DONE: begin
        first_nxt = 1'b0;
        case (unit_r)
          UNIT_SEC: begin
            unit_nxt  = UNIT_MIN;
            state_nxt = ST_DIV_INIT;
          end
          UNIT_MIN: begin
            unit_nxt  = UNIT_HOUR;
            state_nxt = ST_DIV_INIT;
          end
          default: state_nxt = ST_DAY_INIT;
        endcase
      end
      ST_DAY_INIT: state_nxt = ST_DAY_STEP;
      ST_DAY_STEP: begin
        if (st.fits || st.ovf) begin
          state_nxt = ST_PUT;
        end else if (st.new_year) begin
          state_nxt = ST_LEAP_Q;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.unit    = unit_r;
    cmd.use_amt = first_r;
    case (state_r)
      ST_IDLE:     cmd.take     = in_valid;
      ST_LOAD:     cmd.load     = 1'b1;
      ST_LEAP_Q:   cmd.leap_q   = 1'b1;
      ST_LEAP_F:   cmd.leap_f   = 1'b1;
      ST_CLAMP:    cmd.clamp    = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_DIV_DONE: cmd.div_done = 1'b1;
      ST_DAY_INIT: cmd.day_init = 1'b1;
      ST_DAY_STEP: cmd.day_step = 1'b1;
      ST_PUT:      cmd.put      = out_free;
      default:     cmd.take     = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.put) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ADD_SEC;
      unit_r      <= UNIT_SEC;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      unit_r      <= unit_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r != ST_IDLE)
    else $error("accepted item did not start processing");

  a_put_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUT && !out_stall |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented after put");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

endmodule

@@ rtl/core/cdta_dp.sv @@
// Datapath for the date/time adder: start registers, date/time state,
// constant divider, leap-year unit and month/year walker. Depends on cdta_pkg.
module cdta_dp #(
  parameter int AMOUNT_WIDTH = cdta_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdta_pkg::in_item_t               in_data,
  input  logic                             cfg_wr_en,
  input  logic [cdta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdta_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cdta_pkg::cmd_t                   cmd,
  output cdta_pkg::status_t                st,
  output cdta_pkg::out_item_t              out_data
);
  import cdta_pkg::*;

  localparam int W     = AMOUNT_WIDTH + 1;
  localparam int OFF_W = (W > 18) ? W : 18;
  localparam int XW    = W - 2;
  localparam int MW    = W - 1;
  localparam int PW    = XW + MW;

  // floor(x / 60) = floor((x >> 2) / 15) and floor(x / 24) = floor((x >> 3) / 3),
  // each by multiplying with a rounded-up reciprocal
  localparam logic [MW-1:0] RECIP_15 = MW'(((64'd1 << (W + 2)) + 64'd14) / 64'd15);
  localparam logic [MW-1:0] RECIP_3  = MW'(((64'd1 << (W - 1)) + 64'd2) / 64'd3);

  // start values
  logic [13:0] start_year_r;
  logic [3:0]  start_month_r;
  logic [4:0]  start_day_r;
  logic [4:0]  start_hour_r;
  logic [5:0]  start_minute_r;
  logic [5:0]  start_second_r;

  // current date and time
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic        leap_r;
  logic        ovf_r;

  logic [AMOUNT_WIDTH-1:0] amt_r;
  logic [W-1:0]            dvd_r;
  logic [W-1:0]            quo_r;
  logic [OFF_W-1:0]        off_r;
  logic [6:0]              q_r;
  out_item_t               out_r;

  logic [13:0]  y_cl;
  logic [3:0]   m_cl;
  logic [26:0]  prod;
  logic [13:0]  q100;
  logic         leap_nxt;
  logic [4:0]   mlen;
  logic [4:0]   day_cl;
  logic [XW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] quo_prod;
  logic [W-1:0]  quo_nxt;
  logic [5:0]    quo_mul_lo;
  logic [5:0]    rem_lo;
  logic [W-1:0] src;
  logic [W-1:0] unit_val;
  logic [8:0]   ylen;
  logic         skip400;
  logic         year1;
  logic         fits;
  logic         wraps;
  logic         at_max;

  // load clamping
  always_comb begin
    if (start_year_r == 14'd0) begin
      y_cl = 14'd1;
    end else if (start_year_r > MAX_YEAR) begin
      y_cl = MAX_YEAR;
    end else begin
      y_cl = start_year_r;
    end
    if (start_month_r == 4'd0) begin
      m_cl = 4'd1;
    end else if (start_month_r > MAX_MONTH) begin
      m_cl = MAX_MONTH;
    end else begin
      m_cl = start_month_r;
    end
  end

  // leap year: divisible by 4, and not by 100 unless by 400
  assign prod     = 27'(year_r) * 27'(LEAP_RECIP);
  assign q100     = 14'(q_r) * 14'd100;
  assign leap_nxt = (year_r[1:0] == 2'd0) && ((q100 != year_r) || (q_r[1:0] == 2'd0));

  assign mlen = month_len(month_r, leap_r);

  always_comb begin
    if (day_r == 5'd0) begin
      day_cl = 5'd1;
    end else if (day_r > mlen) begin
      day_cl = mlen;
    end else begin
      day_cl = day_r;
    end
  end

  // quotient by 60 or 24 in one registered multiply, remainder from the low bits next cycle
  assign mul_a    = (cmd.unit == UNIT_HOUR) ? {1'b0, dvd_r[W-1:3]} : dvd_r[W-1:2];
  assign mul_b    = (cmd.unit == UNIT_HOUR) ? RECIP_3 : RECIP_15;
  assign quo_prod = PW'(mul_a) * PW'(mul_b);
  assign quo_nxt  = (cmd.unit == UNIT_HOUR) ? W'(quo_prod[PW-1:W-1])
                                            : W'(quo_prod[PW-1:W+2]);

  // remainder is below 64, so the low six bits of x - q*d give it exactly
  assign quo_mul_lo = (cmd.unit == UNIT_HOUR) ? quo_r[5:0] * 6'(HOURS_PER_DAY)
                                              : quo_r[5:0] * 6'(SECS_PER_MIN);
  assign rem_lo     = dvd_r[5:0] - quo_mul_lo;

  assign src = cmd.use_amt ? W'(amt_r) : dvd_r;

  always_comb begin
    case (cmd.unit)
      UNIT_SEC: unit_val = W'(second_r);
      UNIT_MIN: unit_val = W'(minute_r);
      default:  unit_val = W'(hour_r);
    endcase
  end

  // month/year walk
  assign ylen    = leap_r ? 9'd366 : 9'd365;
  assign at_max  = (year_r == MAX_YEAR);
  assign skip400 = (month_r == 4'd1) && (off_r >= OFF_W'(DAYS_400Y))
                   && (year_r <= SKIP_YEAR_MAX);
  assign year1   = (month_r == 4'd1) && (off_r >= OFF_W'(ylen));
  assign fits    = !skip400 && (off_r < OFF_W'(mlen));
  assign wraps   = !skip400 && !fits && (year1 || (month_r == MAX_MONTH));

  assign st.fits     = fits;
  assign st.ovf      = wraps && at_max;
  assign st.new_year = wraps && !at_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r   <= RST_YEAR;
      start_month_r  <= RST_MONTH;
      start_day_r    <= RST_DAY;
      start_hour_r   <= RST_HOUR;
      start_minute_r <= RST_MINUTE;
      start_second_r <= RST_SECOND;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_YEAR:   start_year_r   <= cfg_data;
        CFG_START_MONTH:  start_month_r  <= cfg_data[3:0];
        CFG_START_DAY:    start_day_r    <= cfg_data[4:0];
        CFG_START_HOUR:   start_hour_r   <= cfg_data[4:0];
        CFG_START_MINUTE: start_minute_r <= cfg_data[5:0];
        CFG_START_SECOND: start_second_r <= cfg_data[5:0];
        default:          start_year_r   <= start_year_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= RST_YEAR;
      month_r  <= RST_MONTH;
      day_r    <= RST_DAY;
      hour_r   <= RST_HOUR;
      minute_r <= RST_MINUTE;
      second_r <= RST_SECOND;
      leap_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.take) begin
        ovf_r <= 1'b0;
      end
      if (cmd.load) begin
        year_r   <= y_cl;
        month_r  <= m_cl;
        day_r    <= start_day_r;
        hour_r   <= (start_hour_r > MAX_HOUR) ? MAX_HOUR : start_hour_r;
        minute_r <= (start_minute_r > MAX_MIN_SEC) ? MAX_MIN_SEC : start_minute_r;
        second_r <= (start_second_r > MAX_MIN_SEC) ? MAX_MIN_SEC : start_second_r;
      end
      if (cmd.leap_f) begin
        leap_r <= leap_nxt;
      end
      if (cmd.clamp) begin
        day_r <= day_cl;
      end
      // write back the remainder of the finished unit
      if (cmd.div_done) begin
        case (cmd.unit)
          UNIT_SEC: second_r <= rem_lo;
          UNIT_MIN: minute_r <= rem_lo;
          default:  hour_r   <= rem_lo[4:0];
        endcase
      end
      if (cmd.day_step) begin
        if (skip400) begin
          year_r <= year_r + YEARS_400;
        end else if (fits) begin
          day_r <= off_r[4:0] + 5'd1;
        end else if (wraps && at_max) begin
          // saturate at the last second of the last year
          year_r   <= MAX_YEAR;
          month_r  <= MAX_MONTH;
          day_r    <= 5'd31;
          hour_r   <= MAX_HOUR;
          minute_r <= MAX_MIN_SEC;
          second_r <= MAX_MIN_SEC;
          leap_r   <= 1'b0;
          ovf_r    <= 1'b1;
        end else if (year1) begin
          year_r <= year_r + 14'd1;
        end else if (month_r == MAX_MONTH) begin
          month_r <= 4'd1;
          year_r  <= year_r + 14'd1;
        end else begin
          month_r <= month_r + 4'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      amt_r <= AMOUNT_WIDTH'(in_data.amount);
    end
    if (cmd.leap_q) begin
      q_r <= prod[LEAP_SHIFT +: 7];
    end
    if (cmd.div_init) begin
      dvd_r <= unit_val + src;
    end else if (cmd.div_done) begin
      // carry the quotient into the next unit
      dvd_r <= quo_r;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
    end
    if (cmd.day_init) begin
      off_r <= OFF_W'(day_r - 5'd1) + OFF_W'(src);
    end else if (cmd.day_step) begin
      if (skip400) begin
        off_r <= off_r - OFF_W'(DAYS_400Y);
      end else if (!fits && !wraps) begin
        off_r <= off_r - OFF_W'(mlen);
      end else if (!fits && year1) begin
        off_r <= off_r - OFF_W'(ylen);
      end else if (!fits) begin
        off_r <= off_r - OFF_W'(mlen);
      end
    end
    if (cmd.put) begin
      out_r.cur_year      <= year_r;
      out_r.cur_month     <= month_r;
      out_r.cur_day       <= day_r;
      out_r.cur_hour      <= hour_r;
      out_r.cur_minute    <= minute_r;
      out_r.cur_second    <= second_r;
      out_r.year_overflow <= ovf_r;
    end
  end

  assign out_data = out_r;

  a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.day_step && fits |=> day_r >= 5'd1 && day_r <= month_len(month_r, leap_r))
    else $error("day outside month after walk");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put && ovf_r |=> out_r.cur_year == MAX_YEAR && out_r.cur_month == MAX_MONTH
                         && out_r.cur_second == MAX_MIN_SEC)
    else $error("overflow reported without saturated date");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_done |=> second_r <= MAX_MIN_SEC && minute_r <= MAX_MIN_SEC
                     && hour_r <= MAX_HOUR)
    else $error("time of day out of range after divide");

endmodule

@@ rtl/core/calendar_datetime_adder.sv @@
// Adds of seconds, minutes or hours take each unit up to hours through a sum, a
// reciprocal multiply and a remainder; every add then walks the date by month, by
// 400 years and to the final day, recomputing the leap flag on each new year. Load
// clamps the start values; other codes go straight to the result, which waits while
// out_stall holds. Items go one at a time; the next once the result is registered.
// Synchronous active-low reset gives 2021-01-01 00:00:00 and the same start values.
module calendar_datetime_adder #(
  parameter int AMOUNT_WIDTH = cdta_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cdta_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cdta_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [cdta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdta_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cdta_pkg::*;

  cmd_t    cmd;
  status_t st;

  cdta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  cdta_dp #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule
